// ===== src/tvsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tvsc_pkg
// Shared types and constants for the vertical slab triangle clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package tvsc_pkg;

  localparam int COORD_W   = 24;
  localparam int COLOR_W   = 32;
  localparam int MAG_W     = COORD_W + 1;
  localparam int DIV_STEPS = 4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  typedef struct packed {
    coord_t               first_x;
    coord_t               first_y;
    coord_t               second_x;
    coord_t               second_y;
    coord_t               third_x;
    coord_t               third_y;
    logic [COLOR_W-1:0]   fill_color;
  } tri_in_t;

  typedef struct packed {
    coord_t               corner_a_x;
    coord_t               corner_a_y;
    coord_t               corner_b_x;
    coord_t               corner_b_y;
    coord_t               corner_c_x;
    coord_t               corner_c_y;
    logic [COLOR_W-1:0]   out_color;
    logic                 last_triangle;
  } tri_out_t;

  typedef enum logic {
    REG_CLIP_LEFT  = 1'b0,
    REG_CLIP_RIGHT = 1'b1
  } reg_idx_e;

  localparam coord_t CLIP_LEFT_RST  = '0;
  localparam coord_t CLIP_RIGHT_RST = {1'b0, {(COORD_W-1){1'b1}}};

endpackage

`default_nettype wire

// ===== src/tvsc_clip_pass.sv =====
// ----------------------------------------------------------------------------
// tvsc_clip_pass
// One pipelined clipping pass of a polygon against a vertical edge, with
// pipelined restoring division for the crossing point y.
// ----------------------------------------------------------------------------
`default_nettype none

module tvsc_clip_pass
  import tvsc_pkg::*;
#(
  parameter int   NV      = 3,
  parameter logic KEEP_HI = 1'b1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  vtx_t                         in_vtx_i [NV],
  input  logic [$clog2(NV+1)-1:0]      in_cnt_i,
  input  coord_t                       bound_i,
  input  logic [COLOR_W-1:0]           tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output vtx_t                         out_vtx_o [NV+1],
  output logic [$clog2(NV+2)-1:0]      out_cnt_o,
  output logic [COLOR_W-1:0]           out_tag_o
);

  localparam int CW = $clog2(NV+1);
  localparam int OCW = $clog2(NV+2);
  localparam int IW = (NV > 1) ? $clog2(NV) : 1;
  localparam int DS = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;

  typedef struct packed {
    vtx_t   [NV-1:0]    v;
    coord_t [NV-1:0]    fy;
    logic   [CW-1:0]    cnt;
    logic   [NV-1:0]    cin;
    logic   [NV-1:0]    pin;
    logic   [NV-1:0]    neg;
    coord_t             bound;
    logic [COLOR_W-1:0] tag;
  } side_t;

  logic en;

  // stage 0: differences and magnitudes
  side_t            s0_side_d, s0_side_q;
  logic             s0_v_q;
  logic [MAG_W-1:0] s0_ma_d  [NV], s0_ma_q  [NV];
  logic [MAG_W-1:0] s0_mdy_d [NV], s0_mdy_q [NV];
  logic [MAG_W-1:0] s0_mdx_d [NV], s0_mdx_q [NV];

  // stage 1: product
  side_t              s1_side_q;
  logic               s1_v_q;
  logic [2*MAG_W-1:0] s1_prod_q [NV];
  logic [MAG_W-1:0]   s1_mdx_q  [NV];

  // division stages
  logic             dv_v_q    [DS];
  side_t            dv_side_q [DS];
  logic [MAG_W-1:0] dv_rem_q  [DS][NV], dv_rem_d [DS][NV];
  logic [MAG_W-1:0] dv_lo_q   [DS][NV], dv_lo_d  [DS][NV];
  logic [MAG_W-1:0] dv_dvs_q  [DS][NV];
  logic [MAG_W-1:0] src_rem   [DS][NV];
  logic [MAG_W-1:0] src_lo    [DS][NV];
  logic [MAG_W-1:0] src_dvs   [DS][NV];
  logic             src_v     [DS];
  side_t            src_side  [DS];

  // output stage
  logic             out_v_q;
  vtx_t             out_vtx_d [NV+1], out_vtx_q [NV+1];
  logic [OCW-1:0]   out_cnt_d, out_cnt_q;
  logic [COLOR_W-1:0] out_tag_q;

  assign en          = !out_v_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign out_vtx_o   = out_vtx_q;
  assign out_cnt_o   = out_cnt_q;
  assign out_tag_o   = out_tag_q;

  always_comb begin
    logic [IW-1:0]    pidx;
    logic signed [MAG_W-1:0] dx, dy, da;
    vtx_t             pv;
    s0_side_d       = '0;
    s0_side_d.cnt   = in_cnt_i;
    s0_side_d.bound = bound_i;
    s0_side_d.tag   = tag_i;
    for (int i = 0; i < NV; i++) begin
      s0_side_d.v[i]   = in_vtx_i[i];
      s0_side_d.cin[i] = KEEP_HI ? (in_vtx_i[i].x >= bound_i) : (in_vtx_i[i].x <= bound_i);
    end
    for (int i = 0; i < NV; i++) begin
      if (i == 0) begin
        pidx = IW'(in_cnt_i - CW'(1));
      end else begin
        pidx = IW'(i - 1);
      end
      pv = in_vtx_i[pidx];
      s0_side_d.pin[i] = s0_side_d.cin[pidx];
      s0_side_d.fy[i]  = pv.y;
      dx = {in_vtx_i[i].x[COORD_W-1], in_vtx_i[i].x} - {pv.x[COORD_W-1], pv.x};
      dy = {in_vtx_i[i].y[COORD_W-1], in_vtx_i[i].y} - {pv.y[COORD_W-1], pv.y};
      da = {bound_i[COORD_W-1], bound_i} - {pv.x[COORD_W-1], pv.x};
      s0_side_d.neg[i] = da[MAG_W-1] ^ dy[MAG_W-1] ^ dx[MAG_W-1];
      s0_ma_d[i]  = da[MAG_W-1] ? MAG_W'(-da) : MAG_W'(da);
      s0_mdy_d[i] = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      s0_mdx_d[i] = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    end
  end

  always_comb begin
    for (int l = 0; l < NV; l++) begin
      src_rem[0][l] = s1_prod_q[l][2*MAG_W-1:MAG_W];
      src_lo[0][l]  = s1_prod_q[l][MAG_W-1:0];
      src_dvs[0][l] = s1_mdx_q[l];
    end
    src_v[0]    = s1_v_q;
    src_side[0] = s1_side_q;
    for (int s = 1; s < DS; s++) begin
      for (int l = 0; l < NV; l++) begin
        src_rem[s][l] = dv_rem_q[s-1][l];
        src_lo[s][l]  = dv_lo_q[s-1][l];
        src_dvs[s][l] = dv_dvs_q[s-1][l];
      end
      src_v[s]    = dv_v_q[s-1];
      src_side[s] = dv_side_q[s-1];
    end
  end

  always_comb begin
    logic [MAG_W-1:0] r, lo;
    logic [MAG_W:0]   t, td;
    logic             ge;
    for (int s = 0; s < DS; s++) begin
      for (int l = 0; l < NV; l++) begin
        r  = src_rem[s][l];
        lo = src_lo[s][l];
        for (int k = 0; k < DIV_STEPS; k++) begin
          if (s * DIV_STEPS + k < MAG_W) begin
            t  = {r, lo[MAG_W-1]};
            td = t - {1'b0, src_dvs[s][l]};
            ge = (t >= {1'b0, src_dvs[s][l]});
            r  = ge ? td[MAG_W-1:0] : t[MAG_W-1:0];
            lo = {lo[MAG_W-2:0], ge};
          end
        end
        dv_rem_d[s][l] = r;
        dv_lo_d[s][l]  = lo;
      end
    end
  end

  // crossing y and compaction of the clipped list
  always_comb begin
    side_t            fs;
    logic [MAG_W-1:0] fye, yc;
    vtx_t             cv;
    logic [OCW-1:0]   pos;
    fs  = dv_side_q[DS-1];
    pos = '0;
    for (int i = 0; i <= NV; i++) begin
      out_vtx_d[i] = '0;
    end
    for (int i = 0; i < NV; i++) begin
      fye = {fs.fy[i][COORD_W-1], fs.fy[i]};
      yc  = fs.neg[i] ? (fye - dv_lo_q[DS-1][i]) : (fye + dv_lo_q[DS-1][i]);
      cv.x = fs.bound;
      cv.y = yc[COORD_W-1:0];
      if (int'(fs.cnt) > i) begin
        if (fs.cin[i] != fs.pin[i] && int'(pos) <= NV) begin
          out_vtx_d[pos[CW-1:0]] = cv;
          pos = pos + OCW'(1);
        end
        if (fs.cin[i] && int'(pos) <= NV) begin
          out_vtx_d[pos[CW-1:0]] = fs.v[i];
          pos = pos + OCW'(1);
        end
      end
    end
    out_cnt_d = pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int s = 0; s < DS; s++) begin
        dv_v_q[s] <= 1'b0;
      end
    end else if (en) begin
      s0_v_q  <= in_valid_i;
      s1_v_q  <= s0_v_q;
      out_v_q <= dv_v_q[DS-1];
      for (int s = 0; s < DS; s++) begin
        dv_v_q[s] <= src_v[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_side_q <= s0_side_d;
      s1_side_q <= s0_side_q;
      for (int l = 0; l < NV; l++) begin
        s0_ma_q[l]   <= s0_ma_d[l];
        s0_mdy_q[l]  <= s0_mdy_d[l];
        s0_mdx_q[l]  <= s0_mdx_d[l];
        s1_prod_q[l] <= s0_ma_q[l] * s0_mdy_q[l];
        s1_mdx_q[l]  <= s0_mdx_q[l];
      end
      for (int s = 0; s < DS; s++) begin
        dv_side_q[s] <= src_side[s];
        for (int l = 0; l < NV; l++) begin
          dv_rem_q[s][l] <= dv_rem_d[s][l];
          dv_lo_q[s][l]  <= dv_lo_d[s][l];
          dv_dvs_q[s][l] <= src_dvs[s][l];
        end
      end
      for (int i = 0; i <= NV; i++) begin
        out_vtx_q[i] <= out_vtx_d[i];
      end
      out_cnt_q <= out_cnt_d;
      out_tag_q <= dv_side_q[DS-1].tag;
    end
  end

endmodule

`default_nettype wire

// ===== src/triangle_vertical_slab_clipper.sv =====
// ----------------------------------------------------------------------------
// triangle_vertical_slab_clipper
// Clips a triangle against left <= x <= right and fans the result into up
// to three triangles.
//
//   port        dir  handshake           content
//   in_*        in   in_valid_i/ready_o  one triangle and color word
//   out_*       out  out_valid_o/ready_i one result triangle
//   cfg_*       in   cfg_we_i            slab edge write, no wait
//
// Two clip passes of 10 stages each (differences, multiply, 7 division stages of
// up to 4 quotient bits, compaction) plus the fan stage and output register.
// The fan stage emits one result triangle per cycle unless out_ready_i stalls it,
// and accepts the next item in the cycle it emits the last triangle; items with
// no result pass without output. Full stages hold on a stall; nothing is dropped.
// Reset clears valid bits and sets the slab edges to 0 and the largest x.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_vertical_slab_clipper
  import tvsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tri_in_t             in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tri_out_t            out_o,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [COORD_W-1:0]  cfg_wdata_i
);

  localparam int NV1 = 3;
  localparam int NV2 = NV1 + 1;
  localparam int NF  = NV2 + 1;

  coord_t clip_left_q, clip_right_q;

  vtx_t                       p1_vtx [NV1];
  vtx_t                       p1_out_vtx [NV2];
  logic [$clog2(NV1+2)-1:0]   p1_out_cnt;
  logic [COLOR_W-1:0]         p1_out_tag;
  logic                       p1_out_valid, p2_in_ready;

  vtx_t                       p2_out_vtx [NF];
  logic [$clog2(NV2+2)-1:0]   p2_out_cnt;
  logic [COLOR_W-1:0]         p2_out_tag;
  logic                       p2_out_valid, p2_out_ready;

  logic                       h_v_q;
  vtx_t                       h_vtx_q [NF];
  logic [$clog2(NV2+2)-1:0]   h_cnt_q;
  logic [1:0]                 h_k_q;
  logic [COLOR_W-1:0]         h_color_q;
  logic                       o_v_q;
  tri_out_t                   o_q;

  logic o_can, h_emit, h_last, h_free, h_take;
  logic [2:0] h_b, h_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q  <= CLIP_LEFT_RST;
      clip_right_q <= CLIP_RIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_CLIP_LEFT:  clip_left_q  <= cfg_wdata_i;
        REG_CLIP_RIGHT: clip_right_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    p1_vtx[0] = '{x: in_i.first_x,  y: in_i.first_y};
    p1_vtx[1] = '{x: in_i.second_x, y: in_i.second_y};
    p1_vtx[2] = '{x: in_i.third_x,  y: in_i.third_y};
  end

  tvsc_clip_pass #(.NV(NV1), .KEEP_HI(1'b1)) u_pass_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_vtx_i    (p1_vtx),
    .in_cnt_i    (2'd3),
    .bound_i     (clip_left_q),
    .tag_i       (in_i.fill_color),
    .out_valid_o (p1_out_valid),
    .out_ready_i (p2_in_ready),
    .out_vtx_o   (p1_out_vtx),
    .out_cnt_o   (p1_out_cnt),
    .out_tag_o   (p1_out_tag)
  );

  tvsc_clip_pass #(.NV(NV2), .KEEP_HI(1'b0)) u_pass_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p1_out_valid),
    .in_ready_o  (p2_in_ready),
    .in_vtx_i    (p1_out_vtx),
    .in_cnt_i    (p1_out_cnt),
    .bound_i     (clip_right_q),
    .tag_i       (p1_out_tag),
    .out_valid_o (p2_out_valid),
    .out_ready_i (p2_out_ready),
    .out_vtx_o   (p2_out_vtx),
    .out_cnt_o   (p2_out_cnt),
    .out_tag_o   (p2_out_tag)
  );

  // fan stage
  assign o_can        = !o_v_q || out_ready_i;
  assign h_emit       = h_v_q && (h_cnt_q >= 3'd3) && o_can;
  assign h_last       = ({1'b0, h_k_q} == (h_cnt_q - 3'd2));
  assign h_free       = !h_v_q || (h_cnt_q < 3'd3) || (h_emit && h_last);
  assign p2_out_ready = h_free;
  assign h_take       = p2_out_valid && h_free;
  assign h_b          = {1'b0, h_k_q};
  assign h_c          = h_b + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
      h_k_q <= 2'd1;
      o_v_q <= 1'b0;
    end else begin
      if (h_take) begin
        h_v_q <= 1'b1;
        h_k_q <= 2'd1;
      end else if (h_free) begin
        h_v_q <= 1'b0;
      end else if (h_emit) begin
        h_k_q <= h_k_q + 2'd1;
      end
      if (h_emit) begin
        o_v_q <= 1'b1;
      end else if (out_ready_i) begin
        o_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_take) begin
      for (int i = 0; i < NF; i++) begin
        h_vtx_q[i] <= p2_out_vtx[i];
      end
      h_cnt_q   <= p2_out_cnt;
      h_color_q <= p2_out_tag;
    end
    if (h_emit) begin
      o_q.corner_a_x    <= h_vtx_q[0].x;
      o_q.corner_a_y    <= h_vtx_q[0].y;
      o_q.corner_b_x    <= h_vtx_q[h_b].x;
      o_q.corner_b_y    <= h_vtx_q[h_b].y;
      o_q.corner_c_x    <= h_vtx_q[h_c].x;
      o_q.corner_c_y    <= h_vtx_q[h_c].y;
      o_q.out_color     <= h_color_q;
      o_q.last_triangle <= h_last;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_o       = o_q;

  a_emit_needs_poly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_emit |-> h_v_q && h_cnt_q >= 3'd3)
    else $error("emit without a polygon of three or more vertices");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h_v_q && h_cnt_q >= 3'd3) |-> ({1'b0, h_k_q} <= (h_cnt_q - 3'd2)))
    else $error("fan index past last triangle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_v_q |-> h_cnt_q <= 3'd5)
    else $error("clipped polygon too large");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h_emit && h_last && !h_take) |=> !h_v_q)
    else $error("holding stage not released after last triangle");

endmodule

`default_nettype wire
